// ===== rtl/qts_pkg.sv =====
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types, constants and helpers for the two-stack queue.
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SIZE_W      = 5;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DQ_OUT,
    S_XFER,
    S_DQ_IN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } ram_port_t;

  typedef struct packed {
    logic              valid;
    word_t             data;
    logic [SIZE_W-1:0] size;
    logic [1:0]        status;
  } result_t;

  // total occupancy, kept to the width of the size field
  function automatic logic [SIZE_W-1:0] total_size(cnt_t a, cnt_t b);
    logic [31:0] s;
    s = 32'(a) + 32'(b);
    return s[SIZE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qts_ram.sv =====
// ----------------------------------------------------------------------------
// qts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/qts_ctrl.sv =====
// ----------------------------------------------------------------------------
// qts_ctrl
// Sequencer for the two-stack queue: stack counts, RAM port control and the
// intake-to-outlet transfer loop.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_ctrl
  import qts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] data_in,
  input  wire word_t       intake_rdata,
  input  wire word_t       outlet_rdata,
  input  wire logic        res_taken,
  output ram_port_t        intake_port,
  output ram_port_t        outlet_port,
  output result_t          res
);

  state_t     state, state_next;
  cnt_t       ic, ic_next;
  cnt_t       oc, oc_next;
  logic       pend, pend_next;
  word_t      res_data, res_data_next;
  logic [1:0] res_status, res_status_next;

  cnt_t ic_m1;
  cnt_t oc_m1;

  assign ic_m1 = ic - cnt_t'(1);
  assign oc_m1 = oc - cnt_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ic    <= '0;
      oc    <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      ic    <= ic_next;
      oc    <= oc_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    res_data   <= res_data_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    ic_next         = ic;
    oc_next         = oc;
    pend_next       = pend;
    res_data_next   = res_data;
    res_status_next = res_status;
    intake_port     = '0;
    outlet_port     = '0;
    in_ready        = (state == S_IDLE);
    res.valid       = 1'b0;
    res.data        = res_data;
    res.size        = total_size(ic, oc);
    res.status      = res_status;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_data_next   = '0;
          res_status_next = ST_OK;
          state_next      = S_RESP;
          case (operation)
            OP_ENQUEUE: begin
              if (ic == cnt_t'(STACK_DEPTH) || oc == cnt_t'(STACK_DEPTH)) begin
                res_status_next = ST_OVERFLOW;
              end else begin
                intake_port.we    = 1'b1;
                intake_port.waddr = ic[ADDR_W-1:0];
                intake_port.wdata = data_in;
                ic_next           = ic + cnt_t'(1);
              end
            end
            OP_DEQUEUE: begin
              if (oc != '0) begin
                outlet_port.raddr = oc_m1[ADDR_W-1:0];
                oc_next           = oc_m1;
                state_next        = S_DQ_OUT;
              end else if (ic != '0) begin
                pend_next  = 1'b0;
                state_next = S_XFER;
              end else begin
                res_status_next = ST_UNDERFLOW;
              end
            end
            default: begin
              res_status_next = ST_OK;
            end
          endcase
        end
      end

      S_DQ_OUT: begin
        res_data_next = outlet_rdata;
        state_next    = S_RESP;
      end

      // read intake top each cycle, write the word read last cycle to outlet
      S_XFER: begin
        if (pend) begin
          outlet_port.we    = 1'b1;
          outlet_port.waddr = oc[ADDR_W-1:0];
          outlet_port.wdata = intake_rdata;
          oc_next           = oc + cnt_t'(1);
        end
        intake_port.raddr = ic_m1[ADDR_W-1:0];
        ic_next           = ic_m1;
        if (ic > cnt_t'(1)) begin
          pend_next = 1'b1;
        end else begin
          // bottom entry read, it is the dequeued word
          pend_next  = 1'b0;
          state_next = S_DQ_IN;
        end
      end

      S_DQ_IN: begin
        res_data_next = intake_rdata;
        state_next    = S_RESP;
      end

      S_RESP: begin
        res.valid = 1'b1;
        if (res_taken) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/queue_from_two_stacks_core.sv =====
// ----------------------------------------------------------------------------
// queue_from_two_stacks_core
// FIFO of 32-bit words built from an intake stack and an outlet stack.
// ----------------------------------------------------------------------------
//  channel  | signals                              | notes
//  ---------+--------------------------------------+---------------------------
//  request  | in_valid in_ready operation data_in  | one operation per request
//  result   | out_valid out_ready data_out         | one result per request
//           | queue_size status                    |
//
//  enqueue and size query go from accept through the result state to the result
//  register, a pop from a non-empty outlet stack first passes the outlet read
//  state, and a dequeue that refills the outlet stack first runs the transfer
//  loop, one word per cycle from the intake read port into the outlet stack.
//  in_ready is high only while the sequencer is idle.
//  synchronous reset empties both stacks; RAM contents are not cleared.
//  a stalled result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module queue_from_two_stacks_core
  import qts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic signed [31:0] data_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      data_out,
  output logic [4:0]              queue_size,
  output logic [1:0]              status
);

  ram_port_t intake_port;
  ram_port_t outlet_port;
  word_t     intake_rdata;
  word_t     outlet_rdata;
  result_t   res;
  logic      out_load;

  assign out_load = res.valid && (!out_valid || out_ready);

  qts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .data_in      (data_in),
    .intake_rdata (intake_rdata),
    .outlet_rdata (outlet_rdata),
    .res_taken    (out_load),
    .intake_port  (intake_port),
    .outlet_port  (outlet_port),
    .res          (res)
  );

  qts_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_intake_ram (
    .clk   (clk),
    .we    (intake_port.we),
    .waddr (intake_port.waddr),
    .wdata (intake_port.wdata),
    .raddr (intake_port.raddr),
    .rdata (intake_rdata)
  );

  qts_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_outlet_ram (
    .clk   (clk),
    .we    (outlet_port.we),
    .waddr (outlet_port.waddr),
    .wdata (outlet_port.wdata),
    .raddr (outlet_port.raddr),
    .rdata (outlet_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data_out   <= res.data;
      queue_size <= res.size;
      status     <= res.status;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while sequencer busy");

  a_underflow_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNDERFLOW |-> data_out == '0 && queue_size == '0)
    else $error("underflow result not empty");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVERFLOW |-> data_out == '0)
    else $error("overflow result carries data");

  a_no_result_while_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !res.valid)
    else $error("result pending while idle");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the two-stack queue against a predictor of its occupancy and order.
// Directed requests hit empty, full and refill cases first, then random
// phases of enqueue-heavy and dequeue-heavy traffic run with random idling
// on both sides, a long output stall, and pauses that drain the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import qts_pkg::*;
;

  // codes 2 and 3 both report the occupancy
  localparam logic [1:0] OP_SIZE     = 2'd2;
  localparam logic [1:0] OP_SIZE_ALT = 2'd3;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASES       = 30;
  localparam int PHASE_ITEMS  = 61;

  class qts_scoreboard;
    typedef struct {
      word_t             data;
      logic [SIZE_W-1:0] size;
      logic [1:0]        status;
    } outcome_t;

    outcome_t expected_q[$];
    word_t    intake_mem[STACK_DEPTH];
    word_t    outlet_mem[STACK_DEPTH];
    int       intake_n;
    int       outlet_n;
    int       requests;
    int       results;
    int       mismatches;
    int       overflows;
    int       underflows;
    int       refills;

    function void note_request(logic [1:0] op, word_t word);
      outcome_t o;
      o.data   = '0;
      o.status = ST_OK;
      requests++;
      if (op == OP_ENQUEUE) begin
        if (intake_n >= STACK_DEPTH || outlet_n >= STACK_DEPTH) begin
          o.status = ST_OVERFLOW;
          overflows++;
        end else begin
          intake_mem[intake_n] = word;
          intake_n++;
        end
      end else if (op == OP_DEQUEUE) begin
        if (outlet_n != 0) begin
          outlet_n--;
          o.data = outlet_mem[outlet_n];
        end else if (intake_n != 0) begin
          // intake top goes to outlet bottom, oldest word leaves directly
          while (intake_n > 1 && outlet_n < STACK_DEPTH) begin
            intake_n--;
            outlet_mem[outlet_n] = intake_mem[intake_n];
            outlet_n++;
          end
          o.data   = intake_mem[0];
          intake_n = 0;
          refills++;
        end else begin
          o.status = ST_UNDERFLOW;
          underflows++;
        end
      end
      o.size = SIZE_W'(intake_n + outlet_n);
      expected_q.push_back(o);
    endfunction

    function void check_result(word_t data, logic [SIZE_W-1:0] size, logic [1:0] status);
      outcome_t o;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with no request pending: data %h size %0d status %0d",
                   results, data, size, status);
        return;
      end
      o = expected_q.pop_front();
      if (data !== o.data || size !== o.size || status !== o.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch on result %0d: expected data %h size %0d status %0d,",
                    " got data %h size %0d status %0d"},
                   results, o.data, o.size, o.status, data, size, status);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          operation;
  logic signed [31:0]  data_in;
  logic                out_valid;
  logic                out_ready;
  logic signed [31:0]  data_out;
  logic [4:0]          queue_size;
  logic [1:0]          status;

  qts_scoreboard sb;
  bit            tx_quiet;
  bit            rx_quiet;
  bit            hold_output;
  int            long_holds;
  int            idle_cycles;

  queue_from_two_stacks_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .data_in    (data_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_out   (data_out),
    .queue_size (queue_size),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // monitors and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_request(operation, data_in);
      if (out_valid && out_ready)
        sb.check_result(data_out, queue_size, status);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls, quiet stretches, one long hold-off on demand
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_output) begin
        stall       = HOLD_CYCLES;
        hold_output = 1'b0;
        long_holds++;
      end else if (rx_quiet) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input logic [1:0] op, input word_t word);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    data_in   <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_queue();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int enq_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct) return OP_ENQUEUE;
    if (r < 92) return OP_DEQUEUE;
    return r[0] ? OP_SIZE_ALT : OP_SIZE;
  endfunction

  initial begin
    int enq_pct;
    sb = new();
    in_valid  <= 1'b0;
    operation <= OP_ENQUEUE;
    data_in   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue: size, underflow, alternate size code
    send_request(OP_SIZE, 32'hffff_ffff);
    send_request(OP_DEQUEUE, 32'h1234_5678);
    send_request(OP_SIZE_ALT, 32'h8000_0000);
    // fill the intake stack, then one more is refused
    send_request(OP_ENQUEUE, 32'h8000_0000);
    send_request(OP_ENQUEUE, 32'h7fff_ffff);
    send_request(OP_ENQUEUE, 32'h0000_0000);
    send_request(OP_ENQUEUE, 32'hffff_ffff);
    send_request(OP_ENQUEUE, 32'h0000_0001);
    send_request(OP_ENQUEUE, 32'haaaa_aaaa);
    send_request(OP_ENQUEUE, 32'h5555_5555);
    send_request(OP_ENQUEUE, 32'h1234_5678);
    send_request(OP_ENQUEUE, 32'hdead_beef);
    send_request(OP_SIZE, 32'h0);
    // full refill, pops mixed with new intake, last intake entry returned alone
    send_request(OP_DEQUEUE, 32'h0);
    send_request(OP_ENQUEUE, 32'hcafe_f00d);
    send_request(OP_DEQUEUE, 32'h0);
    send_request(OP_DEQUEUE, 32'h0);
    send_request(OP_SIZE_ALT, 32'h0);
    repeat (6) send_request(OP_DEQUEUE, 32'h0);
    // empty again: both dequeues underflow
    send_request(OP_DEQUEUE, 32'h0);
    send_request(OP_DEQUEUE, 32'h0);
    drain_queue();

    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 30;
        1:       enq_pct = 50;
        default: enq_pct = 75;
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (phase == 6) begin
        // stall the result side while requests keep coming
        hold_output = 1'b1;
        tx_quiet    = 1'b1;
      end
      repeat (PHASE_ITEMS) send_request(pick_op(enq_pct), random_word());
      if (phase == 12 || $urandom_range(0, 3) == 0)
        drain_queue();
    end

    drain_queue();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests, %0d results: %0d overflow refusals, %0d underflows, %0d refills",
             sb.requests, sb.results, sb.overflows, sb.underflows, sb.refills);
    $display("random idling on both sides, %0d long result stall(s), %0d mismatches",
             long_holds, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== queue_from_two_stacks_core.f =====
rtl/qts_pkg.sv
rtl/qts_ram.sv
rtl/qts_ctrl.sv
rtl/queue_from_two_stacks_core.sv
sim/testbench.sv
